@@ design/ccc_pkg.sv @@
package ccc_pkg;

  // Width of the incoming cycle count
  localparam int COUNT_WIDTH = 24;
  localparam int FREQ_WIDTH  = 32;
  localparam int OUT_WIDTH   = 56;
  localparam int PROD_WIDTH  = COUNT_WIDTH + FREQ_WIDTH;
  // Product plus carried remainder can carry one bit further
  localparam int DIV_WIDTH   = PROD_WIDTH + 1;
  localparam int STEP_WIDTH  = $clog2(DIV_WIDTH);

  localparam int ADDR_WIDTH  = 3;
  localparam int DATA_WIDTH  = 32;

  localparam logic [FREQ_WIDTH-1:0] FREQ_RESET = FREQ_WIDTH'(8021247);

  // Register index, taken from the word address bit
  localparam logic REG_SOURCE_FREQ = 1'b0;
  localparam logic REG_DEST_FREQ   = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic add;
    logic div_step;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } stat_t;

endpackage

@@ design/ccc_regs.sv @@
module ccc_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ccc_pkg::ADDR_WIDTH-1:0]       paddr,
  input  logic [ccc_pkg::DATA_WIDTH-1:0]       pwdata,
  output logic [ccc_pkg::DATA_WIDTH-1:0]       prdata,
  output logic                                 pready,
  output logic [ccc_pkg::FREQ_WIDTH-1:0]       source_freq,
  output logic [ccc_pkg::FREQ_WIDTH-1:0]       dest_freq
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_freq <= ccc_pkg::FREQ_RESET;
      dest_freq   <= ccc_pkg::FREQ_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        ccc_pkg::REG_SOURCE_FREQ: source_freq <= pwdata;
        ccc_pkg::REG_DEST_FREQ:   dest_freq   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ccc_pkg::REG_SOURCE_FREQ: prdata = source_freq;
      ccc_pkg::REG_DEST_FREQ:   prdata = dest_freq;
      default:                  prdata = '0;
    endcase
  end

endmodule

@@ design/ccc_ctrl.sv @@
module ccc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ccc_pkg::stat_t  stat,
  output ccc_pkg::cmd_t   cmd
);

  ccc_pkg::state_t state, state_next;
  logic            out_valid_next;

  assign in_stall = rst || (state != ccc_pkg::ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ccc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ccc_pkg::ST_MUL;
        end
      end
      ccc_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ccc_pkg::ST_ADD;
      end
      ccc_pkg::ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ccc_pkg::ST_DIV;
      end
      ccc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ccc_pkg::ST_DONE;
        end
      end
      ccc_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.write_out  = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ccc_pkg::ST_IDLE;
        end
      end
      default: state_next = ccc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ccc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ design/ccc_dpath.sv @@
module ccc_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ccc_pkg::cmd_t                        cmd,
  output ccc_pkg::stat_t                       stat,
  input  logic [ccc_pkg::COUNT_WIDTH-1:0]      cycles_in,
  input  logic [ccc_pkg::FREQ_WIDTH-1:0]       source_freq,
  input  logic [ccc_pkg::FREQ_WIDTH-1:0]       dest_freq,
  output logic [ccc_pkg::OUT_WIDTH-1:0]        cycles_out
);

  logic [ccc_pkg::COUNT_WIDTH-1:0] count;
  logic [ccc_pkg::PROD_WIDTH-1:0]  prod;
  // dividend bits shift out at the top, quotient bits shift in at the bottom
  logic [ccc_pkg::DIV_WIDTH-1:0]   dvd;
  logic [ccc_pkg::FREQ_WIDTH-1:0]  prem;
  logic [ccc_pkg::FREQ_WIDTH-1:0]  carry_remainder;
  logic [ccc_pkg::STEP_WIDTH-1:0]  step;

  logic [ccc_pkg::FREQ_WIDTH-1:0]  divisor;
  logic [ccc_pkg::FREQ_WIDTH:0]    trial;
  logic [ccc_pkg::FREQ_WIDTH:0]    diff;
  logic                            qbit;
  logic [ccc_pkg::FREQ_WIDTH-1:0]  prem_next;
  logic [ccc_pkg::OUT_WIDTH-1:0]   quo_out;

  // zero source frequency divides by one
  assign divisor = (source_freq == '0) ? ccc_pkg::FREQ_WIDTH'(1) : source_freq;

  assign trial     = {prem, dvd[ccc_pkg::DIV_WIDTH-1]};
  assign diff      = trial - {1'b0, divisor};
  assign qbit      = (trial >= {1'b0, divisor});
  assign prem_next = qbit ? diff[ccc_pkg::FREQ_WIDTH-1:0] : trial[ccc_pkg::FREQ_WIDTH-1:0];

  assign stat.div_last = (step == ccc_pkg::STEP_WIDTH'(ccc_pkg::DIV_WIDTH - 1));

  generate
    if (ccc_pkg::DIV_WIDTH > ccc_pkg::OUT_WIDTH) begin : g_sat
      assign quo_out = (|dvd[ccc_pkg::DIV_WIDTH-1:ccc_pkg::OUT_WIDTH]) ? '1
                     : dvd[ccc_pkg::OUT_WIDTH-1:0];
    end else begin : g_fit
      assign quo_out = ccc_pkg::OUT_WIDTH'(dvd);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      count <= cycles_in;
    end
    if (cmd.mul) begin
      // widen both operands so the full product is kept
      prod <= ccc_pkg::PROD_WIDTH'(count) * ccc_pkg::PROD_WIDTH'(dest_freq);
    end
    if (cmd.add) begin
      dvd  <= ccc_pkg::DIV_WIDTH'(prod) + ccc_pkg::DIV_WIDTH'(carry_remainder);
      prem <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      dvd  <= {dvd[ccc_pkg::DIV_WIDTH-2:0], qbit};
      prem <= prem_next;
      step <= step + 1'b1;
    end
    if (cmd.write_out) begin
      cycles_out <= quo_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_remainder <= '0;
    end else if (cmd.write_out) begin
      carry_remainder <= prem;
    end
  end

endmodule

@@ design/clock_domain_cycle_converter.sv @@
// Converts a cycle count in a source clock domain to the equivalent whole
// number of cycles in a destination clock: cycles_out =
// (cycles_in * dest_freq + carried remainder) / source_freq, with the new
// remainder kept for the next beat so rounding error never accumulates.
// Only reset clears the remainder. A source_freq of 0 divides by one. A
// quotient too wide for cycles_out saturates it to all ones. One item at a
// time: an input beat is taken only when the block is idle, and the next
// beat waits until the multiply, the add of the carried remainder, the
// restoring divider that retires one quotient bit per cycle and the
// hand-off are done. A finished result sits in an output register, so a
// new beat is accepted while it waits. Write source_freq (address 0) and
// dest_freq (address 4) only when idle.
module clock_domain_cycle_converter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ccc_pkg::COUNT_WIDTH-1:0]      cycles_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ccc_pkg::OUT_WIDTH-1:0]        cycles_out,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ccc_pkg::ADDR_WIDTH-1:0]       paddr,
  input  logic [ccc_pkg::DATA_WIDTH-1:0]       pwdata,
  output logic [ccc_pkg::DATA_WIDTH-1:0]       prdata,
  output logic                                 pready
);

  logic [ccc_pkg::FREQ_WIDTH-1:0] source_freq;
  logic [ccc_pkg::FREQ_WIDTH-1:0] dest_freq;
  ccc_pkg::cmd_t                  cmd;
  ccc_pkg::stat_t                 stat;

  // frequency registers
  ccc_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .source_freq (source_freq),
    .dest_freq   (dest_freq)
  );

  // sequencer: accept, multiply, add remainder, divide, hand off
  ccc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // multiplier, shift-subtract divider, remainder and output registers
  ccc_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cycles_in   (cycles_in),
    .source_freq (source_freq),
    .dest_freq   (dest_freq),
    .cycles_out  (cycles_out)
  );

endmodule

@@ design/ccc_checker.sv @@
module ccc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [ccc_pkg::OUT_WIDTH-1:0]        cycles_out,
  input logic                                 pready
);

  // one item at a time: stall right after a beat is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // a result needs the whole division, so out_valid must not rise just after a beat is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result too early");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cycles_out))
    else $error("stalled result dropped or changed");

  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind clock_domain_cycle_converter ccc_checker u_ccc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .cycles_out (cycles_out),
  .pready     (pready)
);
